// ===== design/ptdc_pkg.sv =====
// Shared types and constants of the synthesizer divider calculator.
`default_nettype none
package ptdc_pkg;

	localparam int unsigned FREQ_W   = 21;
	localparam int unsigned BW_W     = 4;
	localparam int unsigned XTAL_W   = 16;
	localparam int unsigned VCO_W    = 23;
	localparam int unsigned FRAC_W   = 15;
	localparam int unsigned DIVD_W   = VCO_W + FRAC_W;
	localparam int unsigned REM_W    = XTAL_W - 1;
	localparam int unsigned SEL_W    = 4;
	localparam int unsigned NUM_MULT = 10;
	localparam int unsigned NUM_CMP  = NUM_MULT - 1;
	localparam int unsigned XDIV_W   = 11;
	localparam int unsigned OUT_W    = 48;
	localparam int unsigned IN_W     = 32;

	localparam int unsigned VCO_LIMIT_KHZ = 3560000;
	localparam logic [XTAL_W-1:0] CRYSTAL_RESET = 16'd28800;

	// multiplier index that wins when no listed multiplier fits
	localparam logic [SEL_W-1:0] SEL_DEFAULT = 4'd9;

	localparam logic [6:0] MULT_TAB [NUM_MULT] = '{
		7'd96, 7'd64, 7'd48, 7'd32, 7'd24, 7'd16, 7'd12, 7'd8, 7'd6, 7'd4
	};

	localparam logic [7:0] BAND_TAB [NUM_MULT] = '{
		8'h82, 8'h82, 8'h42, 8'h42, 8'h22, 8'h22, 8'h12, 8'h12, 8'h0A, 8'h0A
	};

	// largest frequency whose product with each of the first nine multipliers stays below the limit
	localparam logic [FREQ_W-1:0] FREQ_MAX [NUM_CMP] = '{
		21'((VCO_LIMIT_KHZ - 1) / 96), 21'((VCO_LIMIT_KHZ - 1) / 64),
		21'((VCO_LIMIT_KHZ - 1) / 48), 21'((VCO_LIMIT_KHZ - 1) / 32),
		21'((VCO_LIMIT_KHZ - 1) / 24), 21'((VCO_LIMIT_KHZ - 1) / 16),
		21'((VCO_LIMIT_KHZ - 1) / 12), 21'((VCO_LIMIT_KHZ - 1) / 8),
		21'((VCO_LIMIT_KHZ - 1) / 6)
	};

	localparam logic [BW_W-1:0] BW_6MHZ = 4'd6;
	localparam logic [BW_W-1:0] BW_7MHZ = 4'd7;

	localparam logic [7:0] CTRL_VCO_HI = 8'h08;
	localparam logic [7:0] CTRL_DIV    = 8'h02;
	localparam logic [7:0] CTRL_BW6    = 8'h80;
	localparam logic [7:0] CTRL_BW7    = 8'h40;
	localparam logic [7:0] BAND_X6     = 8'h0A;
	localparam logic [7:0] BAND_X12    = 8'h12;
	localparam logic [7:0] BAND_X24    = 8'h22;
	localparam logic [7:0] BAND_X48    = 8'h42;
	localparam logic [7:0] BAND_X96    = 8'h82;

	// long division steps per stage; rounding is sampled once the integer bits are done
	localparam int unsigned NUM_DIV = 10;
	localparam int unsigned DIV_STEPS [NUM_DIV] = '{4, 4, 4, 4, 4, 3, 4, 4, 4, 3};
	localparam int unsigned ROUND_STAGE = 6;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [DIVD_W-1:0] work;
		logic              rnd;
		logic [SEL_W-1:0]  sel;
		logic [BW_W-1:0]   bw;
	} div_data_t;

endpackage
`default_nettype wire

// ===== design/ptdc_front.sv =====
// Multiplier selection and VCO product, two pipeline stages.
`default_nettype none
module ptdc_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [ptdc_pkg::FREQ_W-1:0]  freq,
	input  wire logic [ptdc_pkg::BW_W-1:0]    bw,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output ptdc_pkg::div_data_t               out_data
);

	logic                            valid_s1;
	logic [ptdc_pkg::FREQ_W-1:0]     freq_s1;
	logic [ptdc_pkg::BW_W-1:0]       bw_s1;
	logic [ptdc_pkg::SEL_W-1:0]      sel_s1;
	logic                            valid_s2;
	ptdc_pkg::div_data_t             data_s2;

	logic                            ready_s1;
	logic                            ready_s2;
	logic [ptdc_pkg::SEL_W-1:0]      sel_c;
	logic [27:0]                     prod_c;
	logic [ptdc_pkg::VCO_W-1:0]      vco_c;
	ptdc_pkg::div_data_t             data_c;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// first fitting multiplier wins: scan from the last one down
	always_comb begin
		sel_c = ptdc_pkg::SEL_DEFAULT;
		for (int i = ptdc_pkg::NUM_CMP - 1; i >= 0; i--) begin
			if (freq <= ptdc_pkg::FREQ_MAX[i]) begin
				sel_c = ptdc_pkg::SEL_W'(i);
			end
		end
	end

	always_comb begin
		prod_c = {7'd0, freq_s1} * {21'd0, ptdc_pkg::MULT_TAB[sel_s1]};
		vco_c  = prod_c[ptdc_pkg::VCO_W-1:0];
		data_c.rem  = '0;
		data_c.work = {vco_c, {ptdc_pkg::FRAC_W{1'b0}}};
		data_c.rnd  = 1'b0;
		data_c.sel  = sel_s1;
		data_c.bw   = bw_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			freq_s1 <= freq;
			bw_s1   <= bw;
			sel_s1  <= sel_c;
		end
		if (ready_s2 && valid_s1) begin
			data_s2 <= data_c;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule
`default_nettype wire

// ===== design/ptdc_div_stage.sv =====
// One stage of the restoring long division of the VCO by half the crystal.
`default_nettype none
module ptdc_div_stage #(
	parameter int unsigned STEPS = 8,
	parameter bit          ROUND = 1'b0
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [ptdc_pkg::XTAL_W-1:0]  crystal,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire ptdc_pkg::div_data_t          in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output ptdc_pkg::div_data_t               out_data
);

	logic                     valid_s1;
	ptdc_pkg::div_data_t      data_s1;
	logic                     ready_s1;
	ptdc_pkg::div_data_t      nxt_c;
	logic [ptdc_pkg::REM_W-1:0] half_c;
	logic [ptdc_pkg::REM_W-1:0] quarter_c;

	assign half_c    = crystal[ptdc_pkg::XTAL_W-1:1];
	assign quarter_c = {1'b0, crystal[ptdc_pkg::XTAL_W-1:2]};
	assign ready_s1  = !valid_s1 || out_ready;
	assign in_ready  = ready_s1;

	always_comb begin
		logic [ptdc_pkg::REM_W:0] t;
		logic [ptdc_pkg::REM_W:0] diff;
		logic                     ge;
		nxt_c = in_data;
		// the remainder here is the integer remainder: round half up against a quarter crystal
		if (ROUND) begin
			nxt_c.rnd = (in_data.rem >= quarter_c);
		end
		for (int s = 0; s < STEPS; s++) begin
			t    = {nxt_c.rem, nxt_c.work[ptdc_pkg::DIVD_W-1]};
			ge   = (t >= {1'b0, half_c});
			diff = t - {1'b0, half_c};
			nxt_c.rem  = ge ? diff[ptdc_pkg::REM_W-1:0] : t[ptdc_pkg::REM_W-1:0];
			nxt_c.work = {nxt_c.work[ptdc_pkg::DIVD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			data_s1 <= nxt_c;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

// ===== design/ptdc_pack.sv =====
// Rounding, byte assembly and the output register.
`default_nettype none
module ptdc_pack (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [ptdc_pkg::XTAL_W-1:0]  crystal,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire ptdc_pkg::div_data_t          in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [ptdc_pkg::OUT_W-1:0]        out_bytes
);

	logic                              valid_s1;
	logic [ptdc_pkg::OUT_W-1:0]        bytes_s1;
	logic                              ready_s1;
	logic                              zero_c;
	logic [ptdc_pkg::XDIV_W-1:0]       xdiv_c;
	logic [ptdc_pkg::FRAC_W-1:0]       frac_c;
	logic [15:0]                       word_c;
	logic [2:0]                        am_c;
	logic [7:0]                        pm_c;
	logic [7:0]                        lo_c;
	logic [7:0]                        hi_c;
	logic [7:0]                        band_c;
	logic [7:0]                        ctrl_c;

	assign ready_s1 = !valid_s1 || out_ready;
	assign in_ready = ready_s1;

	always_comb begin
		zero_c = (crystal[ptdc_pkg::XTAL_W-1:1] == '0);
		// only the low divider bits reach the bytes
		xdiv_c = in_data.work[ptdc_pkg::XDIV_W+ptdc_pkg::FRAC_W-1:ptdc_pkg::FRAC_W]
			+ {{(ptdc_pkg::XDIV_W-1){1'b0}}, in_data.rnd};
		frac_c = in_data.work[ptdc_pkg::FRAC_W-1:0];
		if (zero_c) begin
			xdiv_c = '0;
			frac_c = '0;
		end
		word_c = {frac_c[ptdc_pkg::FRAC_W-1], frac_c};
		am_c   = xdiv_c[2:0];
		pm_c   = xdiv_c[ptdc_pkg::XDIV_W-1:3];
		// borrow one eighth when the low part is too small
		if (am_c < 3'd2) begin
			lo_c = {5'd0, am_c} + 8'd8;
			hi_c = pm_c - 8'd1;
		end else begin
			lo_c = {5'd0, am_c};
			hi_c = pm_c;
		end
		band_c = ptdc_pkg::BAND_TAB[in_data.sel];
		ctrl_c = ptdc_pkg::CTRL_VCO_HI | (in_data.sel[0] ? ptdc_pkg::CTRL_DIV : 8'd0);
		if (in_data.bw == ptdc_pkg::BW_6MHZ) begin
			ctrl_c = ctrl_c | ptdc_pkg::CTRL_BW6;
		end else if (in_data.bw == ptdc_pkg::BW_7MHZ) begin
			ctrl_c = ctrl_c | ptdc_pkg::CTRL_BW7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			bytes_s1 <= {ctrl_c, band_c, word_c[7:0], word_c[15:8], hi_c, lo_c};
		end
	end

	assign out_valid = valid_s1;
	assign out_bytes = bytes_s1;

endmodule
`default_nettype wire

// ===== design/pll_tuner_divider_calc_core.sv =====
// Top level of the synthesizer divider calculator.
`default_nettype none
// Turns a tuning frequency in kHz and a channel bandwidth into the six synthesizer
// register bytes. The VCO multiplier is picked and multiplied in, the VCO is divided by
// half the crystal in ten stages of long division (integer and fraction bits in one
// run), and the bytes are assembled into the output register: thirteen pipeline stages.
// One beat is taken every cycle while the output is not stalled, and every stage holds
// its beat while the next one cannot take it. The crystal register is read by the
// division and assembly stages directly, so write it only while the pipeline is empty.
module pll_tuner_divider_calc_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,  // crystal_khz
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,    // freq_khz[20:0], bw_mhz[24:21], zero fill
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata     // int_low, int_high, frac_high, frac_low, band, ctrl
);

	logic [ptdc_pkg::XTAL_W-1:0] crystal_q;
	logic                        dv [ptdc_pkg::NUM_DIV+1];
	logic                        dr [ptdc_pkg::NUM_DIV+1];
	ptdc_pkg::div_data_t         dd [ptdc_pkg::NUM_DIV+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crystal_q <= ptdc_pkg::CRYSTAL_RESET;
		end else if (cfg_we) begin
			crystal_q <= cfg_wdata;
		end
	end

	ptdc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.freq      (s_tdata[ptdc_pkg::FREQ_W-1:0]),
		.bw        (s_tdata[ptdc_pkg::FREQ_W+ptdc_pkg::BW_W-1:ptdc_pkg::FREQ_W]),
		.out_valid (dv[0]),
		.out_ready (dr[0]),
		.out_data  (dd[0])
	);

	for (genvar k = 0; k < ptdc_pkg::NUM_DIV; k++) begin : g_div
		ptdc_div_stage #(
			.STEPS (ptdc_pkg::DIV_STEPS[k]),
			.ROUND (k == ptdc_pkg::ROUND_STAGE)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.crystal   (crystal_q),
			.in_valid  (dv[k]),
			.in_ready  (dr[k]),
			.in_data   (dd[k]),
			.out_valid (dv[k+1]),
			.out_ready (dr[k+1]),
			.out_data  (dd[k+1])
		);
	end

	ptdc_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.crystal   (crystal_q),
		.in_valid  (dv[ptdc_pkg::NUM_DIV]),
		.in_ready  (dr[ptdc_pkg::NUM_DIV]),
		.in_data   (dd[ptdc_pkg::NUM_DIV]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_bytes (m_tdata)
	);

	// low divider byte always lands in two to nine after the borrow
	a_low_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] >= 8'd2 && m_tdata[7:0] <= 8'd9))
		else $error("int_low_byte out of range");

	// band byte is one of the table codes and the VCO-high bit is set
	a_band_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[43] && (m_tdata[39:32] == ptdc_pkg::BAND_X96
			|| m_tdata[39:32] == ptdc_pkg::BAND_X48 || m_tdata[39:32] == ptdc_pkg::BAND_X24
			|| m_tdata[39:32] == ptdc_pkg::BAND_X12 || m_tdata[39:32] == ptdc_pkg::BAND_X6)))
		else $error("illegal band or control byte");

	// the last division stage holds its beat behind a stalled output
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && dv[ptdc_pkg::NUM_DIV])
		|=> (dv[ptdc_pkg::NUM_DIV] && $stable(dd[ptdc_pkg::NUM_DIV])))
		else $error("division stage lost a beat during stall");

	// a stalled full output stage blocks the last division stage
	a_last_block: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !dr[ptdc_pkg::NUM_DIV])
		else $error("assembly stage accepts while full");

endmodule
`default_nettype wire

// ===== dv/ptdc_checker.sv =====
// Checker for the synthesizer divider calculator: predicts the register bytes and compares them.
`timescale 1ns / 1ps
module ptdc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	output int          fail_count,
	output int          outstanding
);

	localparam logic [63:0] FRAC_MID  = 64'd16384;
	localparam logic [63:0] FRAC_BIAS = 64'd32768;
	localparam int          MAX_SHOWN = 10;

	typedef struct packed {
		logic [47:0]                 bytes;
		logic [ptdc_pkg::FREQ_W-1:0] freq;
		logic [ptdc_pkg::BW_W-1:0]   bw;
		logic [ptdc_pkg::XTAL_W-1:0] xtal;
	} div_request_t;

	logic [ptdc_pkg::XTAL_W-1:0] crystal_khz;
	div_request_t                divider_bytes_q [$];
	div_request_t                oldest;
	div_request_t                incoming;
	logic                        bad;

	function automatic logic [63:0] vco_mult(input int unsigned idx);
		case (idx)
			0: vco_mult = 64'd96;
			1: vco_mult = 64'd64;
			2: vco_mult = 64'd48;
			3: vco_mult = 64'd32;
			4: vco_mult = 64'd24;
			5: vco_mult = 64'd16;
			6: vco_mult = 64'd12;
			7: vco_mult = 64'd8;
			8: vco_mult = 64'd6;
			default: vco_mult = 64'd4;
		endcase
	endfunction

	// Band byte is shared by each pair of multipliers.
	function automatic logic [7:0] band_for(input int unsigned idx);
		case (idx >> 1)
			0: band_for = ptdc_pkg::BAND_X96;
			1: band_for = ptdc_pkg::BAND_X48;
			2: band_for = ptdc_pkg::BAND_X24;
			3: band_for = ptdc_pkg::BAND_X12;
			default: band_for = ptdc_pkg::BAND_X6;
		endcase
	endfunction

	function automatic logic [47:0] calc_divider_bytes(
			input logic [ptdc_pkg::FREQ_W-1:0] freq,
			input logic [ptdc_pkg::BW_W-1:0] bw, input logic [ptdc_pkg::XTAL_W-1:0] xtal);
		int unsigned sel;
		logic        found;
		logic [63:0] half, quarter, vco, quo, rem, frac, xdiv;
		logic [7:0]  am, pm, lo, hi, ctrl;
		sel   = ptdc_pkg::NUM_MULT - 1;
		found = 1'b0;
		for (int i = 0; i < ptdc_pkg::NUM_MULT - 1; i++) begin
			if (!found && 64'(freq) * vco_mult(i) < 64'(ptdc_pkg::VCO_LIMIT_KHZ)) begin
				sel   = i;
				found = 1'b1;
			end
		end
		vco     = 64'(freq) * vco_mult(sel);
		half    = 64'(xtal) >> 1;
		quarter = 64'(xtal) >> 2;
		quo     = '0;
		rem     = '0;
		frac    = '0;
		if (half != 64'd0) begin
			quo  = vco / half;
			rem  = vco % half;
			frac = (rem << 15) / half;
			if (frac >= FRAC_MID)
				frac = frac + FRAC_BIAS;
			frac = frac & 64'hFFFF;
		end
		xdiv = (half != 64'd0 && rem >= quarter) ? quo + 64'd1 : quo;
		am   = {5'd0, xdiv[2:0]};
		pm   = xdiv[10:3];
		// borrow one eighth when the low part is below two
		if (am < 8'd2) begin
			lo = am + 8'd8;
			hi = pm - 8'd1;
		end else begin
			lo = am;
			hi = pm;
		end
		ctrl = ptdc_pkg::CTRL_VCO_HI | ((sel % 2 == 1) ? ptdc_pkg::CTRL_DIV : 8'h00);
		if (bw == ptdc_pkg::BW_6MHZ)
			ctrl = ctrl | ptdc_pkg::CTRL_BW6;
		else if (bw == ptdc_pkg::BW_7MHZ)
			ctrl = ctrl | ptdc_pkg::CTRL_BW7;
		calc_divider_bytes = {ctrl, band_for(sel), frac[7:0], frac[15:8], hi, lo};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crystal_khz = ptdc_pkg::CRYSTAL_RESET;
			divider_bytes_q.delete();
			fail_count  = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				crystal_khz = cfg_wdata;
			if (s_tvalid && s_tready) begin
				incoming.bytes = calc_divider_bytes(s_tdata[ptdc_pkg::FREQ_W-1:0],
					s_tdata[ptdc_pkg::FREQ_W+ptdc_pkg::BW_W-1:ptdc_pkg::FREQ_W], crystal_khz);
				incoming.freq  = s_tdata[ptdc_pkg::FREQ_W-1:0];
				incoming.bw    = s_tdata[ptdc_pkg::FREQ_W+ptdc_pkg::BW_W-1:ptdc_pkg::FREQ_W];
				incoming.xtal  = crystal_khz;
				divider_bytes_q = {divider_bytes_q, incoming};
			end
			if (m_tvalid && m_tready) begin
				if (divider_bytes_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN)
						$display("unexpected beat %012h with nothing outstanding", m_tdata);
				end else begin
					oldest = divider_bytes_q.pop_front();
					bad    = 1'b0;
					// compare byte by byte: lo, hi, frac hi, frac lo, band, ctrl
					for (int k = 0; k < 6; k++)
						if (oldest.bytes[k*8 +: 8] !== m_tdata[k*8 +: 8])
							bad = 1'b1;
					if (bad) begin
						fail_count++;
						if (fail_count <= MAX_SHOWN)
							$display("mismatch xtal %0d freq %0d bw %0d: expected %012h got %012h",
								oldest.xtal, oldest.freq, oldest.bw, oldest.bytes, m_tdata);
					end
				end
			end
			outstanding <= divider_bytes_q.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the synthesizer divider calculator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int NUM_PHASES   = 10;
	localparam int PHASE_ITEMS  = 50;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 80;
	localparam int HOLD_AFTER   = 60;
	localparam int IDLE_PCT     = 24;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;

	int fail_count;
	int outstanding;
	int cycles     = 0;
	int sent_count = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;
	bit quiet      = 1'b0;

	always #5 clk = ~clk;

	pll_tuner_divider_calc_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ptdc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL pll_tuner_divider_calc_core");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off while the sender keeps pushing.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (!hold_done && sent_count >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic send_beat(input logic [ptdc_pkg::FREQ_W-1:0] freq,
			input logic [ptdc_pkg::BW_W-1:0] bw);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, bw, freq};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_count++;
	endtask

	// Wait until every predicted beat has come out.
	task automatic wait_drained();
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_crystal(input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [ptdc_pkg::FREQ_W-1:0] pick_freq();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			return ptdc_pkg::FREQ_W'($urandom);
		else if (pick < 65)
			return ptdc_pkg::FREQ_W'($urandom_range(1, 2000000));
		else if (pick < 75)
			return ptdc_pkg::FREQ_W'($urandom_range(0, 64));
		// land near a multiplier switch point
		return ptdc_pkg::FREQ_W'(ptdc_pkg::FREQ_MAX[$urandom_range(0, ptdc_pkg::NUM_CMP - 1)]
			+ $urandom_range(0, 4) - 2);
	endfunction

	function automatic logic [ptdc_pkg::BW_W-1:0] pick_bw();
		if ($urandom_range(0, 99) < 25)
			return $urandom_range(0, 1) ? ptdc_pkg::BW_6MHZ : ptdc_pkg::BW_7MHZ;
		return ptdc_pkg::BW_W'($urandom_range(0, 15));
	endfunction

	function automatic logic [15:0] crystal_for(input int phase);
		case (phase)
			1: crystal_for = 16'd40000;
			2: crystal_for = 16'd8000;
			3: crystal_for = 16'd0;
			4: crystal_for = 16'd1;
			5: crystal_for = 16'd2;
			6: crystal_for = 16'hFFFF;
			7: crystal_for = 16'd28800;
			8: crystal_for = 16'($urandom_range(8000, 40000));
			default: crystal_for = 16'($urandom);
		endcase
	endfunction

	initial begin
		int phase;
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// switch points of every multiplier, both sides
		for (n = 0; n < ptdc_pkg::NUM_CMP; n++) begin
			send_beat(ptdc_pkg::FREQ_MAX[n], ptdc_pkg::BW_6MHZ);
			send_beat(ptdc_pkg::FREQ_MAX[n] + 1'b1, ptdc_pkg::BW_7MHZ);
		end
		send_beat('0, 4'd0);
		send_beat(21'd1, 4'hF);
		send_beat(21'd2000000, 4'd8);
		send_beat(21'h1FFFFF, ptdc_pkg::BW_6MHZ);
		send_beat(21'h155555, 4'hA);
		send_beat(21'h0AAAAA, 4'h5);

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase > 0) begin
				s_tvalid <= 1'b0;
				wait_drained();
				write_crystal(crystal_for(phase));
			end
			quiet = (phase == 2);
			for (n = 0; n < PHASE_ITEMS - (phase == 0 ? 5 : 0); n++) begin
				if (phase == 1 && n == PHASE_ITEMS / 2) begin
					s_tvalid <= 1'b0;
					wait_drained();
				end
				send_beat(pick_freq(), pick_bw());
			end
		end
		s_tvalid <= 1'b0;
		quiet = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("PASS pll_tuner_divider_calc_core");
		else
			$display("FAIL pll_tuner_divider_calc_core");
		$finish;
	end

endmodule

// ===== sim.f =====
design/ptdc_pkg.sv
design/ptdc_front.sv
design/ptdc_div_stage.sv
design/ptdc_pack.sv
design/pll_tuner_divider_calc_core.sv
dv/ptdc_checker.sv
dv/tb_top.sv
